FILE: hw/rtl/pipc_pkg.sv
package pipc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int AREA_W      = PROD_W + 1;

  // queue depths must be powers of two (pointers wrap freely)
  localparam int EDGE_QD  = 4;
  localparam int EDGE_QAW = $clog2(EDGE_QD);
  localparam int RES_QD   = 4;
  localparam int RES_QAW  = $clog2(RES_QD);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          first_vertex;
    logic                          last_vertex;
    logic                          last_polygon;
  } in_item_t;

  typedef struct packed {
    logic polygon_inside;
    logic any_inside;
    logic frame_done;
  } out_item_t;

  // classified edge handed from front to back
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] ey;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] ex;
    logic                     test;
    logic                     up;
    logic                     first;
    logic                     last;
    logic                     last_polygon;
  } edge_item_t;

endpackage

FILE: hw/rtl/pipc_front.sv
module pipc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  pipc_pkg::in_item_t  vertex,
  output logic                edge_valid,
  input  logic                edge_pop,
  output pipc_pkg::edge_item_t edge_head
);
  import pipc_pkg::*;

  logic signed [COORD_WIDTH-1:0] prev_x;
  logic signed [COORD_WIDTH-1:0] prev_y;
  edge_item_t                    queue [EDGE_QD];
  logic [EDGE_QAW-1:0]           wr_ptr;
  logic [EDGE_QAW-1:0]           rd_ptr;
  logic [EDGE_QAW:0]             count;
  logic                          accept;
  logic                          take;
  edge_item_t                    cls;
  logic                          rng_up;
  logic                          rng_dn;

  assign full       = (count == (EDGE_QAW + 1)'(EDGE_QD));
  assign edge_valid = (count != '0);
  assign accept     = push && !full;
  assign take       = edge_pop && edge_valid;
  assign edge_head  = queue[rd_ptr];

  always_comb begin
    rng_up = (vertex.query_y >= prev_y) && (vertex.query_y < vertex.vertex_y);
    rng_dn = (vertex.query_y < prev_y) && (vertex.query_y >= vertex.vertex_y);
    cls.dx = {vertex.vertex_x[COORD_WIDTH-1], vertex.vertex_x} - {prev_x[COORD_WIDTH-1], prev_x};
    cls.ey = {vertex.query_y[COORD_WIDTH-1], vertex.query_y} - {prev_y[COORD_WIDTH-1], prev_y};
    cls.dy = {vertex.vertex_y[COORD_WIDTH-1], vertex.vertex_y} - {prev_y[COORD_WIDTH-1], prev_y};
    cls.ex = {vertex.query_x[COORD_WIDTH-1], vertex.query_x} - {prev_x[COORD_WIDTH-1], prev_x};
    cls.test         = !vertex.first_vertex && (rng_up || rng_dn);
    cls.up           = rng_up;
    cls.first        = vertex.first_vertex;
    cls.last         = vertex.last_vertex;
    cls.last_polygon = vertex.last_polygon;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        prev_x <= vertex.vertex_x;
        prev_y <= vertex.vertex_y;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (EDGE_QAW + 1)'(accept) - (EDGE_QAW + 1)'(take);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (EDGE_QAW + 1)'(EDGE_QD))
    else $error("edge queue count past depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (accept && !take) |=> (count == $past(count) + 1'b1))
    else $error("edge queue count lost a transaction");

  a_prev_follow: assert property (@(posedge clk) disable iff (rst)
    accept |=> (prev_y == $past(vertex.vertex_y)))
    else $error("previous vertex not updated");

endmodule

FILE: hw/rtl/pipc_back.sv
module pipc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 edge_valid,
  output logic                 edge_pop,
  input  pipc_pkg::edge_item_t edge_head,
  output logic                 empty,
  input  logic                 pop,
  output pipc_pkg::out_item_t  result
);
  import pipc_pkg::*;

  // stage 1: products
  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_p;
  logic signed [PROD_W-1:0] s1_q;
  logic                     s1_test;
  logic                     s1_up;
  logic                     s1_first;
  logic                     s1_last;
  logic                     s1_lastpoly;

  logic signed [PROD_W-1:0] op_dx;
  logic signed [PROD_W-1:0] op_ey;
  logic signed [PROD_W-1:0] op_dy;
  logic signed [PROD_W-1:0] op_ex;

  logic [AREA_W-1:0] area;
  logic              crossing;
  logic              par_now;
  logic              par_new;
  logic              any_new;
  logic              parity;
  logic              frame_any;
  logic              stall;
  logic              fire;

  out_item_t          res_q [RES_QD];
  logic [RES_QAW-1:0] res_wr;
  logic [RES_QAW-1:0] res_rd;
  logic [RES_QAW:0]   res_count;
  logic               res_full;
  logic               res_push;
  logic               res_take;
  out_item_t          res_new;

  assign res_full = (res_count == (RES_QAW + 1)'(RES_QD));
  assign empty    = (res_count == '0);
  assign result   = res_q[res_rd];
  assign res_take = pop && !empty;

  // only a closing vertex needs a result slot
  assign stall    = s1_valid && s1_last && res_full;
  assign edge_pop = edge_valid && !stall;
  assign fire     = s1_valid && !stall;
  assign res_push = fire && s1_last;

  always_comb begin
    op_dx = PROD_W'(edge_head.dx);
    op_ey = PROD_W'(edge_head.ey);
    op_dy = PROD_W'(edge_head.dy);
    op_ex = PROD_W'(edge_head.ex);
  end

  always_comb begin
    area     = {s1_p[PROD_W-1], s1_p} - {s1_q[PROD_W-1], s1_q};
    // crossing needs area sign to agree with the edge direction
    crossing = s1_test && (s1_up ? (!area[AREA_W-1] && (area != '0)) : area[AREA_W-1]);
    par_now  = s1_first ? 1'b0 : parity;
    par_new  = par_now ^ crossing;
    any_new  = frame_any | par_new;
    res_new.polygon_inside = par_new;
    res_new.any_inside     = any_new;
    res_new.frame_done     = s1_lastpoly;
  end

  always_ff @(posedge clk) begin
    if (edge_pop) begin
      s1_p        <= op_dx * op_ey;
      s1_q        <= op_dy * op_ex;
      s1_test     <= edge_head.test;
      s1_up       <= edge_head.up;
      s1_first    <= edge_head.first;
      s1_last     <= edge_head.last;
      s1_lastpoly <= edge_head.last_polygon;
    end
    if (res_push) begin
      res_q[res_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      parity    <= 1'b0;
      frame_any <= 1'b0;
      res_wr    <= '0;
      res_rd    <= '0;
      res_count <= '0;
    end else begin
      if (!stall) begin
        s1_valid <= edge_valid;
      end
      if (fire) begin
        if (s1_last) begin
          parity    <= 1'b0;
          frame_any <= s1_lastpoly ? 1'b0 : any_new;
        end else begin
          parity <= par_new;
        end
      end
      if (res_push) begin
        res_wr <= res_wr + 1'b1;
      end
      if (res_take) begin
        res_rd <= res_rd + 1'b1;
      end
      res_count <= res_count + (RES_QAW + 1)'(res_push) - (RES_QAW + 1)'(res_take);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_parity_clear: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (parity == 1'b0))
    else $error("parity not cleared after polygon close");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (res_push && s1_lastpoly) |=> (frame_any == 1'b0))
    else $error("frame flag not cleared after frame end");

endmodule

FILE: hw/rtl/point_in_polygon_collision_unit.sv
// Even-odd ray-casting test of a query point against a stream of polygon
// vertices, one vertex per transaction on the input queue, with signed Q16.16
// coordinates and exact products. Each vertex flagged last_vertex yields one
// result transaction with the polygon's inside flag, the running OR over the
// frame and frame_done. A vertex is taken every cycle while the 4-entry edge
// queue has room; the back end takes one edge per cycle through a single
// pair of 33x33 multipliers followed by the area sign and parity stage, and
// stalls only when a closing vertex finds the 4-entry result queue full. A
// result passes through the edge queue, the stage-1 product registers and the
// result queue before it appears on the output ports.
module point_in_polygon_collision_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  pipc_pkg::in_item_t  vertex,
  output logic                empty,
  input  logic                pop,
  output pipc_pkg::out_item_t result
);
  import pipc_pkg::*;

  logic       edge_valid;
  logic       edge_pop;
  edge_item_t edge_head;

  pipc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .vertex     (vertex),
    .edge_valid (edge_valid),
    .edge_pop   (edge_pop),
    .edge_head  (edge_head)
  );

  pipc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .edge_valid (edge_valid),
    .edge_pop   (edge_pop),
    .edge_head  (edge_head),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

FILE: tb/point_in_polygon_collision_unit_test.sv
`timescale 1ns / 100ps

module point_in_polygon_collision_unit_test;
  import pipc_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [4*COORD_WIDTH-1:0] wide_t;

  localparam coord_t COORD_MIN    = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t COORD_MAX    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam int     RANDOM_ITEMS = 750;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     PRINT_CAP    = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    vertex = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;

  // predictor state, mirrors the block after reset
  coord_t      held_x = '0;
  coord_t      held_y = '0;
  bit          odd_crossings = 1'b0;
  bit          frame_hit = 1'b0;

  in_item_t    vertex_backlog[$];
  out_item_t   polygon_verdicts[$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          vertices_taken = 0;
  int          taken_seen = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          rx_hold = 1'b0;

  point_in_polygon_collision_unit dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .vertex (vertex),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string detail);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH @%0t: %s", $time, detail);
    mismatch_count++;
  endtask

  // crossing test for the edge (x1,y1) -> (x2,y2), exact wide arithmetic
  function automatic bit ray_crosses(coord_t qx, coord_t qy, coord_t x1, coord_t y1,
                                     coord_t x2, coord_t y2);
    wide_t dy;
    wide_t area;
    bit    spans;
    spans = (qy >= y1 && qy < y2) || (qy < y1 && qy >= y2);
    dy    = wide_t'(y2) - wide_t'(y1);
    area  = (wide_t'(x2) - wide_t'(x1)) * (wide_t'(qy) - wide_t'(y1))
          - dy * (wide_t'(qx) - wide_t'(x1));
    return spans && ((dy > 0 && area > 0) || (dy < 0 && area < 0));
  endfunction

  task automatic track_vertex(in_item_t v);
    out_item_t verdict;
    if (v.first_vertex)
      odd_crossings = 1'b0;
    else if (ray_crosses(v.query_x, v.query_y, held_x, held_y, v.vertex_x, v.vertex_y))
      odd_crossings = ~odd_crossings;
    held_x = v.vertex_x;
    held_y = v.vertex_y;
    if (v.last_vertex) begin
      frame_hit = frame_hit | odd_crossings;
      verdict.polygon_inside = odd_crossings;
      verdict.any_inside     = frame_hit;
      verdict.frame_done     = v.last_polygon;
      polygon_verdicts.push_back(verdict);
      odd_crossings = 1'b0;
      if (v.last_polygon)
        frame_hit = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 60);
  endfunction

  // mostly near the center so that polygons actually surround the query
  function automatic coord_t pick_coord(coord_t center);
    coord_t c;
    case ($urandom_range(0, 11))
      0:       c = coord_t'($urandom);
      1:       c = COORD_MIN;
      2:       c = COORD_MAX;
      3:       c = center;
      4, 5:    c = center + coord_t'($urandom_range(0, 32'h000F_FFFF)) - coord_t'(32'h0008_0000);
      default: c = center + coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
    endcase
    return c;
  endfunction

  task automatic queue_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
                              bit is_first, bit is_last, bit last_poly);
    in_item_t v;
    v.query_x      = qx;
    v.query_y      = qy;
    v.vertex_x     = vx;
    v.vertex_y     = vy;
    v.first_vertex = is_first;
    v.last_vertex  = is_last;
    v.last_polygon = last_poly;
    vertex_backlog.push_back(v);
  endtask

  // sender
  always @(negedge clk) begin
    bit fresh;
    fresh = (vertices_taken != taken_seen);
    taken_seen = vertices_taken;
    if ($urandom_range(0, 299) == 0)
      tx_steady = ~tx_steady;
    if (rst) begin
      push <= 1'b0;
    end else if (push && !fresh) begin
      push <= 1'b1;  // offer still pending, hold it
    end else if (tx_gap > 0) begin
      push <= 1'b0;
      tx_gap--;
    end else if (vertex_backlog.size() == 0) begin
      push <= 1'b0;
    end else if (!tx_steady && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      tx_gap = pick_gap() - 1;
    end else begin
      push   <= 1'b1;
      vertex <= vertex_backlog[0];
    end
  end

  // receiver
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0)
      rx_steady = ~rx_steady;
    if (rst || rx_hold) begin
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      pop <= 1'b0;
      rx_gap--;
    end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      rx_gap = pick_gap() - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // monitor: predicts on accepted vertices, checks accepted results
  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      if (!rst && push && !full) begin
        track_vertex(vertex);
        void'(vertex_backlog.pop_front());
        vertices_taken++;
      end
      if (!rst && pop && !empty) begin
        if (polygon_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %b with no polygon closed", result));
        end else begin
          want = polygon_verdicts.pop_front();
          if (result.polygon_inside !== want.polygon_inside)
            report_mismatch($sformatf("polygon_inside %b, predicted %b",
                                      result.polygon_inside, want.polygon_inside));
          if (result.any_inside !== want.any_inside)
            report_mismatch($sformatf("any_inside %b, predicted %b",
                                      result.any_inside, want.any_inside));
          if (result.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done %b, predicted %b",
                                      result.frame_done, want.frame_done));
        end
      end
    end
  end

  // long receiver stall in the random part so both internal queues back up
  initial begin
    while (vertices_taken < 200)
      @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    in_item_t v;
    coord_t   qx;
    coord_t   qy;
    int       polys;
    int       corners;
    int       random_items;
    random_items = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // frame around the origin
    queue_vertex(0, 0, COORD_MIN, COORD_MIN, 1, 0, 0);
    queue_vertex(0, 0, COORD_MAX, COORD_MIN, 0, 0, 0);
    queue_vertex(0, 0, COORD_MAX, COORD_MAX, 0, 0, 0);
    queue_vertex(0, 0, COORD_MIN, COORD_MAX, 0, 0, 0);
    queue_vertex(0, 0, COORD_MIN, COORD_MIN, 0, 1, 0);
    // single vertex polygon: always outside
    queue_vertex(0, 0, 7, 7, 1, 1, 0);
    // vertex exactly on the query row; stray last_polygon mid-polygon is ignored
    queue_vertex(0, 0, -5, 0, 1, 0, 0);
    queue_vertex(0, 0, 5, -5, 0, 0, 1);
    queue_vertex(0, 0, 5, 5, 0, 0, 0);
    queue_vertex(0, 0, -5, 0, 0, 1, 0);
    // no first_vertex: edge runs from the previous polygon's closing vertex
    queue_vertex(0, 0, 0, -3, 0, 0, 0);
    queue_vertex(0, 0, 0, 3, 0, 1, 1);
    // frame with the query at the corner of the range
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1, 0, 0);
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 0);
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 0, 0);
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 0, 1, 0);
    // query lies on the edge: zero cross product
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1, 0, 0);
    queue_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 0);
    queue_vertex(COORD_MAX, COORD_MIN, 0, 0, 0, 1, 1);
    // horizontal edge on the query row
    queue_vertex(0, 0, -4, 0, 1, 0, 0);
    queue_vertex(0, 0, 4, 0, 0, 0, 0);
    queue_vertex(0, 0, 0, 9, 0, 1, 1);

    // stimulus waits here until every result is back
    while (vertex_backlog.size() != 0 || polygon_verdicts.size() != 0)
      @(posedge clk);

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        qx = coord_t'($urandom);
        qy = coord_t'($urandom);
      end else begin
        qx = pick_coord(0);
        qy = pick_coord(0);
      end
      polys = $urandom_range(1, 4);
      for (int p = 0; p < polys; p++) begin
        corners = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        for (int k = 0; k < corners; k++) begin
          v.query_x      = qx;
          v.query_y      = qy;
          v.vertex_x     = pick_coord(qx);
          v.vertex_y     = pick_coord(qy);
          v.first_vertex = (k == 0) ? ($urandom_range(0, 19) != 0)
                                    : ($urandom_range(0, 29) == 0);
          v.last_vertex  = (k == corners - 1);
          v.last_polygon = v.last_vertex ? (p == polys - 1 || $urandom_range(0, 19) == 0)
                                         : ($urandom_range(0, 19) == 0);
          // occasional query jitter inside a frame
          if ($urandom_range(0, 49) == 0)
            v.query_x = pick_coord(qx);
          if ($urandom_range(0, 49) == 0)
            v.query_y = pick_coord(qy);
          vertex_backlog.push_back(v);
          random_items++;
        end
      end
    end

    while (vertex_backlog.size() != 0 || polygon_verdicts.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
